FILE: rtl/core/footswitch_press_event_engine_defines.svh
// Assertion macros shared by the footswitch press event engine RTL.
`ifndef FOOTSWITCH_PRESS_EVENT_ENGINE_DEFINES_SVH
`define FOOTSWITCH_PRESS_EVENT_ENGINE_DEFINES_SVH

// Checks a property on every rising clock edge while reset is released.
`define FPE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fpe assertion failed");

// Checks a property on every rising clock edge, reset included.
`define FPE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("fpe assertion failed");

`endif

FILE: rtl/core/fpe_pkg.sv
// Types and constants shared by the footswitch press event engine.
`default_nettype none

package fpe_pkg;

  localparam int unsigned FIRE_MODE_W  = 2;
  localparam int unsigned LONG_TICKS_W = 16;
  localparam int unsigned CFG_INDEX_W  = 4;
  localparam int unsigned CFG_DATA_W   = 16;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // Press mode codes.
  localparam logic [FIRE_MODE_W-1:0] MODE_SHORT      = 2'd0;
  localparam logic [FIRE_MODE_W-1:0] MODE_SHORT_LONG = 2'd1;
  localparam logic [FIRE_MODE_W-1:0] MODE_TOGGLE     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FIRE_MODE      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOMENTARY_MODE = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS     = 4'd2;

  // 40 ticks of 10 ms give a 400 ms long press.
  localparam logic [LONG_TICKS_W-1:0] LONG_TICKS_RESET = 16'd40;

  typedef enum logic [1:0] {
    KIND_TRIGGER = 2'd0,
    KIND_DOWN    = 2'd1,
    KIND_UP      = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [FIRE_MODE_W-1:0]  fire_mode;
    logic                    momentary_mode;
    logic [LONG_TICKS_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic        list_sel;
    event_kind_e event_kind;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/fpe_if.sv
// Handshake interfaces for the tick input, event output and configuration channels.
`default_nettype none

interface fpe_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface fpe_out_if;
  logic       valid;
  logic       ready;
  logic       list_sel;
  logic [1:0] event_kind;
  logic       last;

  modport source (output valid, output list_sel, output event_kind, output last, input ready);
  modport sink (input valid, input list_sel, input event_kind, input last, output ready);
endinterface

interface fpe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpe_pkg::CFG_INDEX_W-1:0] index;
  logic [fpe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fpe_cfg_regs.sv
// Configuration register file of the footswitch press event engine.
`default_nettype none

module fpe_cfg_regs (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  fpe_cfg_if.sink       cfg_i,
  output fpe_pkg::cfg_t cfg_o
);

  fpe_pkg::cfg_t cfg_q;
  fpe_pkg::cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        fpe_pkg::REG_FIRE_MODE: begin
          cfg_d.fire_mode = cfg_i.data[fpe_pkg::FIRE_MODE_W-1:0];
        end
        fpe_pkg::REG_MOMENTARY_MODE: begin
          cfg_d.momentary_mode = cfg_i.data[0];
        end
        fpe_pkg::REG_LONG_TICKS: begin
          cfg_d.long_ticks = cfg_i.data[fpe_pkg::LONG_TICKS_W-1:0];
        end
        default: begin
          // Writes beyond the register list are dropped.
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fire_mode      <= fpe_pkg::MODE_SHORT;
      cfg_q.momentary_mode <= 1'b0;
      cfg_q.long_ticks     <= fpe_pkg::LONG_TICKS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/fpe_press_core.sv
// Press state and event generation for one poll tick.
`default_nettype none

module fpe_press_core #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            level_i,
  input  wire fpe_pkg::cfg_t   cfg_i,
  output logic [1:0]           push_n_o,
  output fpe_pkg::result_t     ev0_o,
  output fpe_pkg::result_t     ev1_o
);

  // Compare width that holds both the counter and the threshold.
  localparam int unsigned CMP_W =
    (HOLD_WIDTH > fpe_pkg::LONG_TICKS_W) ? HOLD_WIDTH : fpe_pkg::LONG_TICKS_W;

  logic                  prev_q, prev_d;
  logic [HOLD_WIDTH-1:0] hold_q, hold_d;
  logic                  long_done_q, long_done_d;
  logic                  toggle_q, toggle_d;
  logic                  latched_q, latched_d;

  logic                  press, release_edge;
  logic                  is_short, is_short_long, is_toggle;
  logic [HOLD_WIDTH-1:0] hold_base, hold_inc;
  logic                  long_done_base;
  logic                  long_hit, short_hit, toggle_hit;
  logic                  a_valid, b_valid;
  fpe_pkg::result_t      a_ev, b_ev;

  always_comb begin
    press         = prev_q & ~level_i;
    release_edge  = ~prev_q & level_i;
    is_short      = (cfg_i.fire_mode == fpe_pkg::MODE_SHORT);
    is_short_long = (cfg_i.fire_mode == fpe_pkg::MODE_SHORT_LONG);
    is_toggle     = (cfg_i.fire_mode == fpe_pkg::MODE_TOGGLE);

    // A press edge starts a fresh count before the held tick is counted.
    hold_base      = press ? '0 : hold_q;
    long_done_base = press ? 1'b0 : long_done_q;
    hold_inc       = (&hold_base) ? hold_base : hold_base + HOLD_WIDTH'(1);

    toggle_hit = press & is_toggle;
    long_hit   = ~level_i & is_short_long & ~long_done_base &
                 (CMP_W'(hold_inc) >= CMP_W'(cfg_i.long_ticks));
    short_hit  = release_edge &
                 (is_short | (is_short_long & ~long_done_q &
                  (CMP_W'(hold_q) < CMP_W'(cfg_i.long_ticks))));

    b_valid             = toggle_hit | long_hit | short_hit;
    b_ev.list_sel       = toggle_hit ? toggle_q : long_hit;
    b_ev.event_kind     = fpe_pkg::KIND_TRIGGER;
    b_ev.last           = 1'b1;

    // The down or up event always comes ahead of the trigger of the same tick.
    a_valid             = cfg_i.momentary_mode & (press | release_edge);
    a_ev.list_sel       = is_toggle & (press ? toggle_q : latched_q);
    a_ev.event_kind     = press ? fpe_pkg::KIND_DOWN : fpe_pkg::KIND_UP;
    a_ev.last           = ~b_valid;

    ev0_o    = a_valid ? a_ev : b_ev;
    ev1_o    = b_ev;
    push_n_o = step_i ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;

    prev_d      = level_i;
    hold_d      = release_edge ? '0 : (~level_i ? hold_inc : hold_q);
    long_done_d = release_edge ? 1'b0 : (long_hit | long_done_base);
    toggle_d    = toggle_q ^ toggle_hit;
    latched_d   = (toggle_hit & cfg_i.momentary_mode) ? toggle_q : latched_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b1;
      hold_q      <= '0;
      long_done_q <= 1'b0;
      toggle_q    <= 1'b0;
      latched_q   <= 1'b0;
    end else if (step_i) begin
      prev_q      <= prev_d;
      hold_q      <= hold_d;
      long_done_q <= long_done_d;
      toggle_q    <= toggle_d;
      latched_q   <= latched_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fpe_result_fifo.sv
// Four-entry result queue: up to two events in a cycle, one out when ready.
`default_nettype none
`include "footswitch_press_event_engine_defines.svh"

module fpe_result_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       push_n_i,
  input  wire fpe_pkg::result_t ev0_i,
  input  wire fpe_pkg::result_t ev1_i,
  output logic                  room_o,
  fpe_out_if.source             out_o
);

  localparam int unsigned PW = fpe_pkg::FIFO_PTR_W;
  localparam int unsigned CW = fpe_pkg::FIFO_CNT_W;

  fpe_pkg::result_t        mem_q [fpe_pkg::FIFO_DEPTH];
  logic [PW-1:0]           wr_ptr_q, wr_ptr_d, wr_next;
  logic [PW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    pop;
  logic                    pop_only;
  fpe_pkg::result_t        head;

  assign wr_next  = wr_ptr_q + PW'(1);
  assign pop      = out_o.valid & out_o.ready;
  assign pop_only = pop & (push_n_i == 2'd0);
  assign head     = mem_q[rd_ptr_q];

  // Room means two free entries, so a full tick's worth of events always fits.
  assign room_o = (count_q <= CW'(fpe_pkg::FIFO_DEPTH - 2));

  assign out_o.valid      = (count_q != '0);
  assign out_o.list_sel   = head.list_sel;
  assign out_o.event_kind = head.event_kind;
  assign out_o.last       = head.last;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= ev0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_next] <= ev1_i;
    end
  end

  `FPE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(fpe_pkg::FIFO_DEPTH))
  `FPE_ASSERT(a_push_has_room, clk_i, rst_ni, (push_n_i != 2'd0) |-> room_o)
  `FPE_ASSERT(a_pop_only, clk_i, rst_ni, pop_only |=> (count_q == $past(count_q) - CW'(1)))
  `FPE_ASSERT(a_push_code, clk_i, rst_ni, push_n_i != 2'd3)

endmodule

`default_nettype wire

FILE: rtl/core/footswitch_press_event_engine.sv
// Top level of the footswitch press event engine.
//
// Each input word is one 10 ms poll tick carrying the switch level (0 pressed,
// 1 released). The tick is taken into an input register and, once the result
// queue has room, a single pass of logic updates the press state (last level,
// saturating hold counter of HOLD_WIDTH bits, long-press flag, A/B toggle bit,
// latched list) and writes zero, one or two event words into a four-entry
// result queue. Each output word names the action list, the event kind
// (trigger, down or up) and carries a last flag on the final event of its
// tick. A tick is taken every cycle as long as the queue holds two free
// entries; the queue drains one word per cycle while the output is ready. A
// tick waits in the input register, and its event words in the result queue.
// Configuration writes are taken every cycle and should be made while no tick
// is in flight; a write to an index beyond the register list is ignored.
`default_nettype none

module footswitch_press_event_engine #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpe_in_if.sink    in_i,
  fpe_out_if.source out_o,
  fpe_cfg_if.sink   cfg_i
);

  fpe_pkg::cfg_t    cfg;
  fpe_pkg::result_t ev0, ev1;
  logic [1:0]       push_n;
  logic             room;

  // Input register: holds one tick until the queue has room for its events.
  logic in_valid_q, in_valid_d;
  logic level_q;
  logic advance;

  assign advance    = in_valid_q & room;
  assign in_i.ready = ~in_valid_q | advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      level_q <= in_i.level;
    end
  end

  fpe_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // The press state only moves when a tick leaves the input register.
  fpe_press_core #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_press_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .level_i  (level_q),
    .cfg_i    (cfg),
    .push_n_o (push_n),
    .ev0_o    (ev0),
    .ev1_o    (ev1)
  );

  fpe_result_fifo u_result_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .ev0_i    (ev0),
    .ev1_i    (ev1),
    .room_o   (room),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/footswitch_press_event_engine_test.sv
// Self-checking testbench for the footswitch press event engine.
module footswitch_press_event_engine_test;
  import fpe_pkg::*;

  localparam int unsigned HOLD_WIDTH = 16;

  // Ticks that cause no event word still take time to leave the pipeline;
  // SETTLE_CYCLES gives them that time after the last expected word.
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_TICKS    = 1450;
  localparam int unsigned PHASE_TICKS     = 100;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  // The scoreboard keeps its own copy of the press state and registers. Each
  // accepted tick is run through the same rules as the block, and the event
  // words it should cause are queued in order. Every word that leaves the
  // block is checked against the oldest one waiting.
  class press_event_scoreboard;
    cfg_t                  cfg;
    logic                  prev_level;
    logic [HOLD_WIDTH-1:0] hold_count;
    logic                  long_done;
    logic                  toggle_bit;
    logic                  latched_sel;
    result_t               expected_events[$];
    int unsigned           errors;

    function new();
      cfg.fire_mode      = MODE_SHORT;
      cfg.momentary_mode = 1'b0;
      cfg.long_ticks     = LONG_TICKS_RESET;
      prev_level         = 1'b1;
      hold_count         = '0;
      long_done          = 1'b0;
      toggle_bit         = 1'b0;
      latched_sel        = 1'b0;
      errors             = 0;
    endfunction

    // Indexes beyond the register list are dropped, as the block does.
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FIRE_MODE:      cfg.fire_mode = data[FIRE_MODE_W-1:0];
        REG_MOMENTARY_MODE: cfg.momentary_mode = data[0];
        REG_LONG_TICKS:     cfg.long_ticks = data[LONG_TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_event(logic sel, event_kind_e kind);
      result_t word;
      word.list_sel   = sel;
      word.event_kind = kind;
      word.last       = 1'b0;
      expected_events.push_back(word);
    endfunction

    function void note_tick(logic level);
      int first;
      first = expected_events.size();
      // Press edge: restart the hold, then down and toggle events.
      if (prev_level && !level) begin
        hold_count = '0;
        long_done  = 1'b0;
        if (cfg.momentary_mode) begin
          if (cfg.fire_mode == MODE_TOGGLE) begin
            latched_sel = toggle_bit;
            push_event(toggle_bit, KIND_DOWN);
          end else begin
            push_event(1'b0, KIND_DOWN);
          end
        end
        if (cfg.fire_mode == MODE_TOGGLE) begin
          push_event(toggle_bit, KIND_TRIGGER);
          toggle_bit = ~toggle_bit;
        end
      end
      // Held: the counter saturates, and a long press fires once.
      if (!level) begin
        if (hold_count != '1) begin
          hold_count = hold_count + 1'b1;
        end
        if (cfg.fire_mode == MODE_SHORT_LONG && !long_done &&
            hold_count >= cfg.long_ticks) begin
          push_event(1'b1, KIND_TRIGGER);
          long_done = 1'b1;
        end
      end
      // Release edge: up event, then a short trigger where one is due.
      if (!prev_level && level) begin
        if (cfg.momentary_mode) begin
          push_event((cfg.fire_mode == MODE_TOGGLE) ? latched_sel : 1'b0, KIND_UP);
        end
        if (cfg.fire_mode == MODE_SHORT) begin
          push_event(1'b0, KIND_TRIGGER);
        end else if (cfg.fire_mode == MODE_SHORT_LONG && !long_done &&
                     hold_count < cfg.long_ticks) begin
          push_event(1'b0, KIND_TRIGGER);
        end
        hold_count = '0;
        long_done  = 1'b0;
      end
      prev_level = level;
      if (expected_events.size() > first) begin
        expected_events[expected_events.size()-1].last = 1'b1;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] event check failed: %s", $time, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected word sel=%0b kind=%0d last=%0b",
                                  got.list_sel, got.event_kind, got.last));
      end else begin
        want = expected_events.pop_front();
        if (got.list_sel !== want.list_sel || got.event_kind !== want.event_kind ||
            got.last !== want.last) begin
          report_mismatch($sformatf(
            "sel=%0b kind=%0d last=%0b, wanted sel=%0b kind=%0d last=%0b",
            got.list_sel, got.event_kind, got.last,
            want.list_sel, want.event_kind, want.last));
        end
      end
    endtask

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fpe_in_if  tick_if();
  fpe_out_if evt_if();
  fpe_cfg_if cfg_if();

  footswitch_press_event_engine #(
    .HOLD_WIDTH(HOLD_WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tick_if),
    .out_o (evt_if),
    .cfg_i (cfg_if)
  );

  press_event_scoreboard sb = new();

  // Idling controls shared between the stimulus and the event sink.
  bit          sender_gaps_on = 1'b1;
  bit          sink_gaps_on   = 1'b1;
  bit          hold_off_req   = 1'b0;
  int unsigned cycle_count    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, none when switched off.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned roll;
    if (!enabled) begin
      return 0;
    end
    roll = $urandom_range(0, 15);
    if (roll < 9) begin
      return 0;
    end else if (roll < 15) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  // Fills the bits above a register's width with noise, which the block must mask.
  function automatic logic [CFG_DATA_W-1:0] pad_upper(int unsigned value, int unsigned width);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    return (noise << width) | CFG_DATA_W'(value);
  endfunction

  // Offers one tick word after a random gap; valid stays high on return so
  // that a following tick goes out back to back.
  task automatic send_tick(logic level);
    int unsigned gap;
    gap = pick_gap(sender_gaps_on);
    repeat (gap) begin
      tick_if.valid = 1'b0;
      @(negedge clk_i);
    end
    tick_if.valid = 1'b1;
    tick_if.level = level;
    @(posedge clk_i);
    while (!tick_if.ready) begin
      @(posedge clk_i);
    end
    sb.note_tick(level);
    @(negedge clk_i);
  endtask

  task automatic send_run(logic level, int unsigned count);
    repeat (count) begin
      send_tick(level);
    end
  endtask

  // Stops offering ticks until every expected word has come back, then lets
  // ticks that cause no word leave the pipeline as well.
  task automatic wait_idle();
    tick_if.valid = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes all three registers and one index beyond the list, holding valid
  // high across the burst.
  task automatic program_regs(logic [CFG_DATA_W-1:0] mode_data,
                              logic [CFG_DATA_W-1:0] mom_data,
                              logic [CFG_DATA_W-1:0] ticks_data);
    logic [CFG_INDEX_W-1:0] idx_list [4];
    logic [CFG_DATA_W-1:0]  data_list [4];
    idx_list[0]  = CFG_INDEX_W'($urandom_range(3, 15));
    data_list[0] = CFG_DATA_W'($urandom);
    idx_list[1]  = REG_FIRE_MODE;
    data_list[1] = mode_data;
    idx_list[2]  = REG_MOMENTARY_MODE;
    data_list[2] = mom_data;
    idx_list[3]  = REG_LONG_TICKS;
    data_list[3] = ticks_data;
    wait_idle();
    cfg_if.valid = 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_if.index = idx_list[i];
      cfg_if.data  = data_list[i];
      @(posedge clk_i);
      while (!cfg_if.ready) begin
        @(posedge clk_i);
      end
      sb.write_reg(idx_list[i], data_list[i]);
      @(negedge clk_i);
    end
    cfg_if.valid = 1'b0;
  endtask

  // Event sink: ready is changed on the falling edge. A hold-off request holds
  // ready low, so the result queue fills and the block stops taking ticks.
  initial begin : event_sink
    int unsigned stall_left;
    stall_left   = 0;
    evt_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        evt_if.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        evt_if.ready = 1'b0;
        stall_left--;
      end else begin
        evt_if.ready = 1'b1;
        stall_left   = pick_gap(sink_gaps_on);
      end
    end
  end

  // Event words are taken on the rising edge where valid and ready are high.
  initial begin : event_monitor
    result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && evt_if.valid && evt_if.ready) begin
        got.list_sel   = evt_if.list_sel;
        got.event_kind = event_kind_e'(evt_if.event_kind);
        got.last       = evt_if.last;
        sb.check_result(got);
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_ticks;
    int unsigned phase_ticks;
    int unsigned roll;
    int unsigned hold_len;
    int unsigned rel_len;
    int unsigned noise_len;
    int unsigned mode_val;
    int unsigned ticks_val;

    rst_ni        = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.level = 1'b1;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. Reset settings: a plain short press fires list A on
    // release, and an idle released tick fires nothing.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Zero threshold in short-long mode with down and up events: the long
    // trigger comes on the first held tick and the release fires only its up event.
    program_regs(pad_upper(MODE_SHORT_LONG, FIRE_MODE_W), pad_upper(1, 1), 16'd0);
    send_run(1'b0, 2);
    send_tick(1'b1);

    // Toggle mode: presses alternate lists, and the up event follows the
    // list latched at the press.
    program_regs(pad_upper(MODE_TOGGLE, FIRE_MODE_W), pad_upper(1, 1), 16'hFFFF);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // The unused press mode fires only down and up events on list A.
    program_regs(pad_upper(3, FIRE_MODE_W), pad_upper(1, 1), 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Short-long without momentary events: a press under the threshold fires
    // short, one that reaches it fires long once and nothing on release.
    program_regs(pad_upper(MODE_SHORT_LONG, FIRE_MODE_W), pad_upper(0, 1), 16'd2);
    send_tick(1'b0);
    send_tick(1'b1);
    send_run(1'b0, 3);
    send_tick(1'b1);

    // Back pressure: the sink holds off while toggle presses keep coming,
    // so the result queue fills and the tick input stalls.
    program_regs(pad_upper(MODE_TOGGLE, FIRE_MODE_W), pad_upper(1, 1), 16'd40);
    sender_gaps_on = 1'b0;
    sink_gaps_on   = 1'b0;
    hold_off_req   = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_tick(i[0]);
    end
    wait_idle();

    // Largest threshold: a long hold that stays under it fires no long
    // trigger, and the release fires short.
    program_regs(pad_upper(MODE_SHORT_LONG, FIRE_MODE_W), pad_upper(1, 1), 16'hFFFF);
    send_run(1'b0, 60);
    send_tick(1'b1);

    // Random part: each phase picks new settings, then mostly plays whole
    // presses whose length straddles the threshold, mixed with noise and
    // the odd pause until everything has drained.
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      mode_val = $urandom_range(0, 3);
      roll     = $urandom_range(0, 15);
      if (roll == 0) begin
        ticks_val = 0;
      end else if (roll == 1) begin
        ticks_val = 1;
      end else if (roll == 2) begin
        ticks_val = 16'hFFFF;
      end else begin
        ticks_val = $urandom_range(2, 50);
      end
      program_regs(pad_upper(mode_val, FIRE_MODE_W), pad_upper($urandom_range(0, 1), 1),
                   CFG_DATA_W'(ticks_val));
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      sink_gaps_on   = ($urandom_range(0, 3) != 0);

      phase_ticks = 0;
      while (phase_ticks < PHASE_TICKS) begin
        roll = $urandom_range(0, 99);
        if (roll < 84) begin
          if (ticks_val <= 1) begin
            hold_len = $urandom_range(1, 8);
          end else if (ticks_val > 50) begin
            hold_len = $urandom_range(1, 60);
          end else begin
            hold_len = $urandom_range(1, ticks_val + 4);
          end
          rel_len = $urandom_range(1, 6);
          send_run(1'b0, hold_len);
          send_run(1'b1, rel_len);
          phase_ticks += hold_len + rel_len;
        end else if (roll < 98) begin
          noise_len = $urandom_range(1, 6);
          repeat (noise_len) begin
            send_tick(1'($urandom_range(0, 1)));
          end
          phase_ticks += noise_len;
        end else begin
          wait_idle();
        end
      end
      random_ticks += phase_ticks;
    end

    // Drain and finish.
    tick_if.valid = 1'b0;
    sink_gaps_on  = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
